@@ rtl/core/integer_literal_parser_top_defines.svh @@
// Assertion macros shared by the integer literal parser modules.
// Both expect clk_i and rst_ni in the scope of the use.
`ifndef INTEGER_LITERAL_PARSER_TOP_DEFINES_SVH
`define INTEGER_LITERAL_PARSER_TOP_DEFINES_SVH

// Same-cycle implication.
`define ILP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("integer literal parser: check failed");

// Next-cycle implication.
`define ILP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("integer literal parser: check failed");

`endif

@@ rtl/core/ilp_pkg.sv @@
`default_nettype none

package ilp_pkg;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2,
    RX_OCT = 2'd3
  } ilp_radix_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_END      = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_REAL     = 3'd4
  } ilp_status_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_new;
    logic       input_end;
  } ilp_item_t;

  typedef struct packed {
    logic [63:0] value;
    ilp_status_e status;
    ilp_radix_e  radix;
    logic [7:0]  consumed;
  } ilp_result_t;

  // Overflow limits: the largest accumulator that still takes one more digit
  localparam logic [63:0] LimDec = 64'h1999_9999_9999_9999;
  localparam logic [63:0] LimHex = 64'h0fff_ffff_ffff_ffff;
  localparam logic [63:0] LimBin = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] LimOct = 64'h1fff_ffff_ffff_ffff;

  localparam logic [7:0] Char0     = 8'h30;
  localparam logic [7:0] Char9     = 8'h39;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] CharLowE  = 8'h65;
  localparam logic [7:0] CharUpE   = 8'h45;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CharUpX   = 8'h58;
  localparam logic [7:0] CharLowB  = 8'h62;
  localparam logic [7:0] CharUpB   = 8'h42;
  localparam logic [7:0] CharLowO  = 8'h6f;
  localparam logic [7:0] CharUpO   = 8'h4f;

  // Bit 4 set: not a digit of the radix
  localparam logic [4:0] NoDigit = 5'h10;

  function automatic logic [4:0] digit_of(logic [7:0] c, ilp_radix_e rx);
    logic [4:0] d;
    logic [4:0] res;
    d = NoDigit;
    if (c >= Char0 && c <= Char9) begin
      d = {1'b0, c[3:0]};
    end else if ((c >= CharLowA && c <= CharLowF) || (c >= CharUpA && c <= CharUpF)) begin
      d = {1'b0, c[3:0] + 4'd9};
    end
    res = d;
    if (!d[4]) begin
      case (rx)
        RX_HEX: res = d;
        RX_BIN: res = (d < 5'd2)  ? d : NoDigit;
        RX_OCT: res = (d < 5'd8)  ? d : NoDigit;
        default: res = (d < 5'd10) ? d : NoDigit;
      endcase
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ilp_acc.sv @@
`default_nettype none

// Shift-and-add of one digit with exact overflow check.
module ilp_acc (
  input  wire logic [63:0]         acc_i,
  input  wire ilp_pkg::ilp_radix_e radix_i,
  input  wire logic [3:0]          digit_i,
  output logic      [63:0]         acc_o,
  output logic                     ovf_o
);

  logic [63:0] shifted;

  always_comb begin
    shifted = acc_i;
    ovf_o   = 1'b0;
    unique case (radix_i)
      ilp_pkg::RX_HEX: begin
        ovf_o   = acc_i > ilp_pkg::LimHex;
        shifted = acc_i << 4;
      end
      ilp_pkg::RX_BIN: begin
        ovf_o   = acc_i > ilp_pkg::LimBin;
        shifted = acc_i << 1;
      end
      ilp_pkg::RX_OCT: begin
        ovf_o   = acc_i > ilp_pkg::LimOct;
        shifted = acc_i << 3;
      end
      ilp_pkg::RX_DEC: begin
        ovf_o   = (acc_i > ilp_pkg::LimDec) ||
                  ((acc_i == ilp_pkg::LimDec) && (digit_i > 4'd5));
        shifted = (acc_i << 3) + (acc_i << 1);
      end
    endcase
    // drop the old value once it no longer fits
    acc_o = (ovf_o ? 64'd0 : shifted) + 64'(digit_i);
  end

endmodule

`default_nettype wire

@@ rtl/core/ilp_step.sv @@
`default_nettype none

// Literal state machine: consumes one character per fire, holds parse state.
module ilp_step (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire ilp_pkg::ilp_item_t  item_i,
  output logic                     emit_o,
  output ilp_pkg::ilp_result_t     res_o
);

  `include "integer_literal_parser_top_defines.svh"

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ZERO   = 2'd1,
    PH_PREFIX = 2'd2,
    PH_DIGITS = 2'd3
  } phase_e;

  phase_e              phase_q, phase_d;
  ilp_pkg::ilp_radix_e radix_q, radix_d;
  logic [63:0]         acc_q, acc_d;
  logic                ovf_q, ovf_d;
  logic [7:0]          cnt_q, cnt_d;

  logic [4:0]  dig;
  logic [63:0] acc_nxt;
  logic        add_ovf;
  logic        do_digits;
  logic        do_finish;
  logic [7:0]  c;

  assign c   = item_i.ch;
  assign dig = ilp_pkg::digit_of(c, radix_q);

  ilp_acc u_acc (
    .acc_i   (acc_q),
    .radix_i (radix_q),
    .digit_i (dig[3:0]),
    .acc_o   (acc_nxt),
    .ovf_o   (add_ovf)
  );

  always_comb begin
    phase_d   = phase_q;
    radix_d   = radix_q;
    acc_d     = acc_q;
    ovf_d     = ovf_q;
    cnt_d     = cnt_q;
    emit_o    = 1'b0;
    do_digits = 1'b0;
    do_finish = 1'b0;
    res_o     = '{value: 64'd0, status: ilp_pkg::ST_OK, radix: radix_q, consumed: cnt_q};

    if (fire_i) begin
      if (item_i.start_new) begin
        radix_d = ilp_pkg::RX_DEC;
        acc_d   = 64'd0;
        ovf_d   = 1'b0;
        cnt_d   = 8'd0;
        phase_d = PH_IDLE;
        res_o.radix    = ilp_pkg::RX_DEC;
        res_o.consumed = 8'd0;
        if (item_i.input_end) begin
          emit_o       = 1'b1;
          res_o.status = ilp_pkg::ST_END;
        end else if (c == ilp_pkg::CharDot) begin
          emit_o       = 1'b1;
          res_o.status = ilp_pkg::ST_REAL;
        end else if (c < ilp_pkg::Char0 || c > ilp_pkg::Char9) begin
          emit_o       = 1'b1;
          res_o.status = ilp_pkg::ST_INVALID;
        end else begin
          cnt_d   = 8'd1;
          acc_d   = 64'(c[3:0]);
          phase_d = (c == ilp_pkg::Char0) ? PH_ZERO : PH_DIGITS;
        end
      end else begin
        unique case (phase_q)
          PH_ZERO: begin
            if (item_i.input_end) begin
              do_finish = 1'b1;
            end else if (c == ilp_pkg::CharLowX || c == ilp_pkg::CharUpX) begin
              radix_d = ilp_pkg::RX_HEX;
              cnt_d   = 8'd2;
              phase_d = PH_PREFIX;
            end else if (c == ilp_pkg::CharLowB || c == ilp_pkg::CharUpB) begin
              radix_d = ilp_pkg::RX_BIN;
              cnt_d   = 8'd2;
              phase_d = PH_PREFIX;
            end else if (c == ilp_pkg::CharLowO || c == ilp_pkg::CharUpO) begin
              radix_d = ilp_pkg::RX_OCT;
              cnt_d   = 8'd2;
              phase_d = PH_PREFIX;
            end else begin
              do_digits = 1'b1;
            end
          end
          PH_PREFIX: begin
            if (item_i.input_end) begin
              emit_o       = 1'b1;
              res_o.status = ilp_pkg::ST_END;
            end else if (dig[4]) begin
              emit_o       = 1'b1;
              res_o.status = ilp_pkg::ST_INVALID;
            end else begin
              do_digits = 1'b1;
            end
          end
          PH_DIGITS: begin
            if (item_i.input_end) begin
              do_finish = 1'b1;
            end else begin
              do_digits = 1'b1;
            end
          end
          default: ;
        endcase

        if (do_digits) begin
          if (!dig[4]) begin
            acc_d   = acc_nxt;
            ovf_d   = ovf_q | add_ovf;
            cnt_d   = (cnt_q == 8'hff) ? cnt_q : cnt_q + 8'd1;
            phase_d = PH_DIGITS;
          end else if (radix_q == ilp_pkg::RX_DEC &&
                       (c == ilp_pkg::CharDot || c == ilp_pkg::CharLowE ||
                        c == ilp_pkg::CharUpE)) begin
            emit_o       = 1'b1;
            res_o.status = ilp_pkg::ST_REAL;
          end else begin
            do_finish = 1'b1;
          end
        end

        if (do_finish) begin
          emit_o = 1'b1;
          if (ovf_q) begin
            res_o.status = ilp_pkg::ST_OVERFLOW;
          end else begin
            res_o.value = acc_q;
          end
        end
      end
      if (emit_o) begin
        phase_d = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      radix_q <= ilp_pkg::RX_DEC;
      acc_q   <= 64'd0;
      ovf_q   <= 1'b0;
      cnt_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      radix_q <= radix_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      cnt_q   <= cnt_d;
    end
  end

  `ILP_ASSERT_IMP(a_prefix_radix, phase_q == PH_PREFIX, radix_q != ilp_pkg::RX_DEC)
  `ILP_ASSERT_IMP(a_zero_state, phase_q == PH_ZERO, (acc_q == 64'd0) && (cnt_q == 8'd1))
  `ILP_ASSERT_IMP(a_no_emit_idle, !fire_i, !emit_o)

endmodule

`default_nettype wire

@@ rtl/core/integer_literal_parser_top.sv @@
`default_nettype none

// Integer literal parser. Feed the characters of a literal one per input
// transfer, with start_new_i on the first one; an optional 0x, 0b or 0o
// prefix selects hex, binary or octal, otherwise the literal is decimal.
// The first character that is not a digit of the base, or a transfer with
// input_end_i, closes the literal and yields one output transfer carrying
// the value, the status, the radix code and the count of characters taken
// (prefix included, terminator excluded, saturating at 255). Any status
// other than ok reports a value of zero. A decimal literal that meets '.',
// 'e' or 'E' is only flagged as a real literal. Rate: one character per
// cycle while the output is not stalled; the limit is the loop through the
// accumulator register and its shift-and-add (times ten for decimal).
// The closing character passes the input register, then the result
// register, before out_valid_o rises. Both channels use valid/stall;
// a stalled output holds its payload and backs up into the input register,
// which then raises in_stall_o.
module integer_literal_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        start_new_i,
  input  wire logic        input_end_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [63:0] value_o,
  output logic      [2:0]  status_o,
  output logic      [1:0]  radix_code_o,
  output logic      [7:0]  consumed_o
);

  `include "integer_literal_parser_top_defines.svh"

  logic                  in_valid_q;
  ilp_pkg::ilp_item_t    item_q;
  logic                  out_valid_q;
  ilp_pkg::ilp_result_t  res_q;

  logic                  out_free;
  logic                  fire;
  logic                  step_emit;
  ilp_pkg::ilp_result_t  step_res;

  // The result register can load when empty or when its transfer completes.
  assign out_free   = !out_valid_q || !out_stall_i;
  // Advance the held character whenever its result, if any, has a place.
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // Input register: take a new transfer whenever the held one moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= '{ch: ch_i, start_new: start_new_i, input_end: input_end_i};
    end
  end

  ilp_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .emit_o (step_emit),
    .res_o  (step_res)
  );

  // Result register: hold while stalled, drop valid after a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && step_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && step_emit) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = res_q.value;
  assign status_o     = res_q.status;
  assign radix_code_o = res_q.radix;
  assign consumed_o   = res_q.consumed;

  `ILP_ASSERT_IMP(a_err_value_zero, out_valid_o && (status_o != ilp_pkg::ST_OK), value_o == 64'd0)
  `ILP_ASSERT_IMP(a_real_is_dec, out_valid_o && (status_o == ilp_pkg::ST_REAL), radix_code_o == ilp_pkg::RX_DEC)
  `ILP_ASSERT_NXT(a_result_loaded, fire && step_emit, out_valid_o)
  `ILP_ASSERT_IMP(a_status_legal, out_valid_o, status_o <= ilp_pkg::ST_REAL)

endmodule

`default_nettype wire
